/* rtl/pwa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwa_pkg
// Types, codes and helpers shared by the two-level page walk access core.
// ----------------------------------------------------------------------------
package pwa_pkg;

  // input modes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_RESP  = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_FETCH  = 3'd0;
  localparam logic [2:0] KIND_READ   = 3'd1;
  localparam logic [2:0] KIND_WRITE  = 3'd2;
  localparam logic [2:0] KIND_RESULT = 3'd3;
  localparam logic [2:0] KIND_FAULT  = 3'd4;

  // fault causes
  localparam logic [1:0] CAUSE_NONE  = 2'd0;
  localparam logic [1:0] CAUSE_DIR   = 2'd1;
  localparam logic [1:0] CAUSE_TABLE = 2'd2;
  localparam logic [1:0] CAUSE_CROSS = 2'd3;

  // configuration register indexes
  localparam logic CFG_PAGING    = 1'b0;
  localparam logic CFG_DIR_FRAME = 1'b1;

  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [12:0] PAGE_BYTES = 13'h1000;
  localparam logic [2:0]  MAX_LEN    = 3'd4;
  localparam logic [2:0]  ENTRY_LEN  = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PDE  = 4'b0010,
    ST_PTE  = 4'b0100,
    ST_DATA = 4'b1000
  } stage_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] virt_addr;
    logic [2:0]  access_len;
    logic [31:0] store_data;
    logic [31:0] mem_data;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] phys_addr;
    logic [2:0]  byte_count;
    logic [31:0] out_data;
    logic [1:0]  fault_cause;
  } result_t;

  function automatic logic [31:0] byte_mask(input logic [2:0] n);
    logic [31:0] m;
    unique case (n)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

/* rtl/pwa_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwa_in_reg
// Input register: holds one accepted beat until the walk stage takes it.
// ----------------------------------------------------------------------------
module pwa_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  pwa_pkg::item_t in_item,
  input  logic           advance,
  output logic           hold_valid,
  output pwa_pkg::item_t hold_item
);
  import pwa_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign valid_nxt  = (in_valid && in_ready) || (valid_r && !advance);
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

/* rtl/pwa_walk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwa_walk
// Walk state and single-pass step logic: one item in, at most one result out.
// ----------------------------------------------------------------------------
module pwa_walk (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  pwa_pkg::item_t   item,
  input  logic             paging_en,
  input  logic [19:0]      dir_frame,
  output logic             res_valid,
  output pwa_pkg::result_t res,
  output pwa_pkg::stage_t  stage
);
  import pwa_pkg::*;

  stage_t      stage_r, stage_nxt;
  logic [31:0] pending_vaddr_r, pending_vaddr_nxt;
  logic [2:0]  pending_len_r, pending_len_nxt;
  logic        pending_is_write_r, pending_is_write_nxt;
  logic [31:0] pending_store_r, pending_store_nxt;
  logic [31:0] low_part_r, low_part_nxt;
  logic [2:0]  low_bytes_r, low_bytes_nxt;
  logic        second_half_r, second_half_nxt;

  logic [2:0]  len_sat;
  logic [12:0] req_end;
  logic [12:0] req_room;
  logic        req_cross;
  logic [2:0]  req_low;
  logic [31:0] next_va;
  logic [31:0] part_va;
  logic [2:0]  part_len;
  logic [2:0]  upper_len;
  logic [31:0] resp_part;
  logic [31:0] spliced;

  assign stage = stage_r;

  always_comb begin
    len_sat   = (item.access_len > MAX_LEN) ? MAX_LEN : item.access_len;
    req_end   = {1'b0, item.virt_addr[11:0]} + {10'd0, len_sat};
    req_room  = PAGE_BYTES - {1'b0, item.virt_addr[11:0]};
    req_cross = req_end > PAGE_BYTES;
    // when crossing, the room left is below the length, so three bits hold it
    req_low   = req_cross ? req_room[2:0] : len_sat;
    next_va   = {pending_vaddr_r[31:12] + 20'd1, 12'h000};
    part_va   = second_half_r ? next_va : pending_vaddr_r;
    upper_len = pending_len_r - low_bytes_r;
    part_len  = second_half_r ? upper_len : low_bytes_r;
    resp_part = item.mem_data & byte_mask(part_len);
    unique case (low_bytes_r)
      3'd1:    spliced = low_part_r | {resp_part[23:0], 8'd0};
      3'd2:    spliced = low_part_r | {resp_part[15:0], 16'd0};
      3'd3:    spliced = low_part_r | {resp_part[7:0], 24'd0};
      default: spliced = low_part_r;
    endcase
  end

  always_comb begin
    stage_nxt            = stage_r;
    pending_vaddr_nxt    = pending_vaddr_r;
    pending_len_nxt      = pending_len_r;
    pending_is_write_nxt = pending_is_write_r;
    pending_store_nxt    = pending_store_r;
    low_part_nxt         = low_part_r;
    low_bytes_nxt        = low_bytes_r;
    second_half_nxt      = second_half_r;
    res_valid            = 1'b0;
    res                  = '0;

    if (item.mode == MODE_READ || item.mode == MODE_WRITE) begin
      if (stage_r == ST_IDLE) begin
        pending_vaddr_nxt    = item.virt_addr;
        pending_len_nxt      = len_sat;
        pending_is_write_nxt = item.mode[0];
        pending_store_nxt    = item.store_data;
        low_part_nxt         = '0;
        second_half_nxt      = 1'b0;
        low_bytes_nxt        = req_low;
        res_valid            = 1'b1;
        if (item.mode == MODE_WRITE && req_cross) begin
          res.kind        = KIND_FAULT;
          res.fault_cause = CAUSE_CROSS;
        end else if (paging_en) begin
          stage_nxt      = ST_PDE;
          res.kind       = KIND_FETCH;
          res.phys_addr  = {dir_frame, item.virt_addr[31:22], 2'b00};
          res.byte_count = ENTRY_LEN;
        end else if (item.mode == MODE_WRITE) begin
          res.kind       = KIND_WRITE;
          res.phys_addr  = item.virt_addr;
          res.byte_count = len_sat;
          res.out_data   = item.store_data & byte_mask(len_sat);
        end else begin
          stage_nxt      = ST_DATA;
          res.kind       = KIND_READ;
          res.phys_addr  = item.virt_addr;
          res.byte_count = req_low;
        end
      end
    end else if (item.mode == MODE_RESP) begin
      unique case (stage_r)
        ST_PDE: begin
          res_valid = 1'b1;
          if (!item.mem_data[0]) begin
            stage_nxt       = ST_IDLE;
            res.kind        = KIND_FAULT;
            res.fault_cause = CAUSE_DIR;
          end else begin
            stage_nxt      = ST_PTE;
            res.kind       = KIND_FETCH;
            res.phys_addr  = {item.mem_data[31:12], part_va[21:12], 2'b00};
            res.byte_count = ENTRY_LEN;
          end
        end
        ST_PTE: begin
          res_valid = 1'b1;
          if (!item.mem_data[0]) begin
            stage_nxt       = ST_IDLE;
            res.kind        = KIND_FAULT;
            res.fault_cause = CAUSE_TABLE;
          end else if (pending_is_write_r) begin
            stage_nxt      = ST_IDLE;
            res.kind       = KIND_WRITE;
            res.phys_addr  = {item.mem_data[31:12], part_va[11:0]};
            res.byte_count = pending_len_r;
            res.out_data   = pending_store_r & byte_mask(pending_len_r);
          end else begin
            stage_nxt      = ST_DATA;
            res.kind       = KIND_READ;
            res.phys_addr  = {item.mem_data[31:12], part_va[11:0]};
            res.byte_count = part_len;
          end
        end
        ST_DATA: begin
          res_valid = 1'b1;
          if (!second_half_r && low_bytes_r < pending_len_r) begin
            // low part done, start on the next page
            low_part_nxt    = resp_part;
            second_half_nxt = 1'b1;
            if (paging_en) begin
              stage_nxt      = ST_PDE;
              res.kind       = KIND_FETCH;
              res.phys_addr  = {dir_frame, next_va[31:22], 2'b00};
              res.byte_count = ENTRY_LEN;
            end else begin
              stage_nxt      = ST_DATA;
              res.kind       = KIND_READ;
              res.phys_addr  = next_va;
              res.byte_count = upper_len;
            end
          end else begin
            stage_nxt      = ST_IDLE;
            res.kind       = KIND_RESULT;
            res.byte_count = pending_len_r;
            res.out_data   = second_half_r ? spliced : resp_part;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r            <= ST_IDLE;
      pending_vaddr_r    <= '0;
      pending_len_r      <= '0;
      pending_is_write_r <= 1'b0;
      pending_store_r    <= '0;
      low_part_r         <= '0;
      low_bytes_r        <= '0;
      second_half_r      <= 1'b0;
    end else if (advance) begin
      stage_r            <= stage_nxt;
      pending_vaddr_r    <= pending_vaddr_nxt;
      pending_len_r      <= pending_len_nxt;
      pending_is_write_r <= pending_is_write_nxt;
      pending_store_r    <= pending_store_nxt;
      low_part_r         <= low_part_nxt;
      low_bytes_r        <= low_bytes_nxt;
      second_half_r      <= second_half_nxt;
    end
  end

endmodule

/* rtl/pwa_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwa_out_reg
// Result register: holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module pwa_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  pwa_pkg::result_t load_res,
  input  logic             out_ready,
  output logic             out_valid,
  output logic             free,
  output pwa_pkg::result_t out_res
);
  import pwa_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

endmodule

/* rtl/two_level_page_walk_access_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_walk_access_core
// Two-level x86 page walk front end: turns read/write requests and memory
// responses into entry fetches, data accesses, read results and faults.
// ----------------------------------------------------------------------------
//  channel | signals                                   | role
//  in      | in_valid/in_ready, in_mode .. in_mem_data | request or memory response
//  out     | out_valid/out_ready, out_kind .. out_data | command, read result or fault
//  cfg     | cfg_we, cfg_index, cfg_wdata              | paging enable, directory frame
//
// one beat per cycle sustained while out is not stalled; a beat is held in the
// input register and its result is then loaded into the result register.
// synchronous active-low reset clears the walk state, the config registers and both valid flags.
// a stall on out holds the result register and then the input register;
// a beat that gives no result still waits for a free result slot.
// ----------------------------------------------------------------------------
module two_level_page_walk_access_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_virt_addr,
  input  logic [2:0]  in_access_len,
  input  logic [31:0] in_store_data,
  input  logic [31:0] in_mem_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [31:0] out_phys_addr,
  output logic [2:0]  out_byte_count,
  output logic [31:0] out_data,
  output logic [1:0]  out_fault_cause,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_wdata
);
  import pwa_pkg::*;

  logic        paging_en_r;
  logic [19:0] dir_frame_r;

  item_t   in_item;
  item_t   hold_item;
  logic    hold_valid;
  logic    advance;
  logic    out_free;
  logic    res_valid;
  logic    res_load;
  result_t res;
  result_t out_res;
  stage_t  stage;

  assign in_item.mode       = in_mode;
  assign in_item.virt_addr  = in_virt_addr;
  assign in_item.access_len = in_access_len;
  assign in_item.store_data = in_store_data;
  assign in_item.mem_data   = in_mem_data;

  assign advance  = hold_valid && out_free;
  assign res_load = advance && res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      paging_en_r <= 1'b0;
      dir_frame_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAGING:    paging_en_r <= cfg_wdata[0];
        CFG_DIR_FRAME: dir_frame_r <= cfg_wdata[CFG_DATA_W-1:0];
        default:       paging_en_r <= paging_en_r;
      endcase
    end
  end

  pwa_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  pwa_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item      (hold_item),
    .paging_en (paging_en_r),
    .dir_frame (dir_frame_r),
    .res_valid (res_valid),
    .res       (res),
    .stage     (stage)
  );

  pwa_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .load_res  (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .free      (out_free),
    .out_res   (out_res)
  );

  assign out_kind        = out_res.kind;
  assign out_phys_addr   = out_res.phys_addr;
  assign out_byte_count  = out_res.byte_count;
  assign out_data        = out_res.out_data;
  assign out_fault_cause = out_res.fault_cause;

`ifndef SYNTHESIS
  // an entry fetch always leaves the walk waiting on a table entry
  a_fetch_waits: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && res.kind == KIND_FETCH |=> (stage == ST_PDE || stage == ST_PTE))
    else $error("entry fetch issued but walk not waiting on an entry");

  // writes, faults and read results end the request
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_load && (res.kind == KIND_WRITE || res.kind == KIND_FAULT ||
                 res.kind == KIND_RESULT) |=> stage == ST_IDLE)
    else $error("request finished but walk not idle");

  // fault cause is set exactly on fault results
  a_fault_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == KIND_FAULT) == (out_fault_cause != CAUSE_NONE)))
    else $error("fault cause does not match result kind");
`endif

endmodule
